// File: rtl/kfdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfdd_pkg
// Shared types and constants of the keyed frame deframer / descrambler.
// ----------------------------------------------------------------------------
package kfdd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned KIND_W  = 2;

  // Header is key byte plus 16-bit little-endian total length.
  localparam logic [LEN_W-1:0] HDR_BYTES    = 16'd3;
  localparam logic [LEN_W-1:0] MAX_BODY_RST = 16'd8192;

  typedef enum logic [KIND_W-1:0] {
    EV_DATA      = 2'd0,
    EV_EMPTY     = 2'd1,
    EV_TOO_LARGE = 2'd2
  } event_kind_t;

  // Header byte position while reading a header.
  localparam logic [1:0] HDR_KEY    = 2'd0;
  localparam logic [1:0] HDR_LEN_LO = 2'd1;
  localparam logic [1:0] HDR_LEN_HI = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] msg_key;
    logic [LEN_W-1:0]  body_length;
    event_kind_t       event_kind;
    logic              last_of_message;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/kfdd_descram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfdd_descram
// Per-byte descramble: out = (b ^ key ^ (len - i)) - (i ^ key), mod 256; key 0 passes b.
// ----------------------------------------------------------------------------
module kfdd_descram (
  input  wire logic [kfdd_pkg::BYTE_W-1:0] key,
  input  wire logic [kfdd_pkg::LEN_W-1:0]  body_len,
  input  wire logic [kfdd_pkg::LEN_W-1:0]  body_idx,
  input  wire logic [kfdd_pkg::BYTE_W-1:0] byte_in,
  output logic      [kfdd_pkg::BYTE_W-1:0] byte_out
);
  import kfdd_pkg::*;

  logic [LEN_W-1:0]  remain;
  logic [BYTE_W-1:0] mixed;

  always_comb begin
    remain = body_len - body_idx;
    mixed  = byte_in ^ key ^ remain[BYTE_W-1:0];
    // A zero key passes bytes through unchanged.
    if (key == '0) begin
      byte_out = byte_in;
    end else begin
      byte_out = mixed - (body_idx[BYTE_W-1:0] ^ key);
    end
  end

endmodule
`default_nettype wire

// File: rtl/kfdd_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfdd_frame
// Frame tracker: header parsing, length check, body indexing and result build.
// ----------------------------------------------------------------------------
module kfdd_frame (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic [kfdd_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [kfdd_pkg::LEN_W-1:0]  max_body_size,
  output kfdd_pkg::result_t                res
);
  import kfdd_pkg::*;

  logic              in_body_r, in_body_nxt;
  logic [1:0]        header_count_r, header_count_nxt;
  logic [BYTE_W-1:0] frame_key_r, frame_key_nxt;
  logic [LEN_W-1:0]  frame_body_length_r, frame_body_length_nxt;
  logic [LEN_W-1:0]  body_index_r, body_index_nxt;

  logic [LEN_W-1:0]  total;
  logic [LEN_W-1:0]  body;
  logic [LEN_W:0]    idx_inc;
  logic [BYTE_W-1:0] plain;

  kfdd_descram u_descram (
    .key      (frame_key_r),
    .body_len (frame_body_length_r),
    .body_idx (body_index_r),
    .byte_in  (rx_byte),
    .byte_out (plain)
  );

  always_comb begin
    in_body_nxt           = in_body_r;
    header_count_nxt      = header_count_r;
    frame_key_nxt         = frame_key_r;
    frame_body_length_nxt = frame_body_length_r;
    body_index_nxt        = body_index_r;

    total   = {rx_byte, frame_body_length_r[BYTE_W-1:0]};
    body    = total - HDR_BYTES;
    idx_inc = {1'b0, body_index_r} + {{LEN_W{1'b0}}, 1'b1};

    res                 = '0;
    res.msg_key         = frame_key_r;
    res.event_kind      = EV_DATA;

    if (!in_body_r) begin
      if (header_count_r == HDR_KEY) begin
        frame_key_nxt    = rx_byte;
        res.msg_key      = rx_byte;
        header_count_nxt = HDR_LEN_LO;
      end else if (header_count_r == HDR_LEN_LO) begin
        frame_body_length_nxt = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
        header_count_nxt      = HDR_LEN_HI;
      end else begin
        frame_body_length_nxt = body;
        header_count_nxt      = HDR_KEY;
        body_index_nxt        = '0;
        if (total == HDR_BYTES) begin
          res.valid           = 1'b1;
          res.event_kind      = EV_EMPTY;
          res.last_of_message = 1'b1;
        end else if ((total < HDR_BYTES) || (body > max_body_size)) begin
          res.valid           = 1'b1;
          res.body_length     = body;
          res.event_kind      = EV_TOO_LARGE;
          res.last_of_message = 1'b1;
        end else begin
          in_body_nxt = 1'b1;
        end
      end
    end else begin
      res.valid       = 1'b1;
      res.data_byte   = plain;
      res.body_length = frame_body_length_r;
      body_index_nxt  = idx_inc[LEN_W-1:0];
      if (idx_inc >= {1'b0, frame_body_length_r}) begin
        res.last_of_message = 1'b1;
        in_body_nxt         = 1'b0;
        header_count_nxt    = HDR_KEY;
        body_index_nxt      = '0;
      end
    end

    // Only a request that advances out of the input register counts.
    res.valid = res.valid && adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r           <= 1'b0;
      header_count_r      <= HDR_KEY;
      frame_key_r         <= '0;
      frame_body_length_r <= '0;
      body_index_r        <= '0;
    end else if (adv) begin
      in_body_r           <= in_body_nxt;
      header_count_r      <= header_count_nxt;
      frame_key_r         <= frame_key_nxt;
      frame_body_length_r <= frame_body_length_nxt;
      body_index_r        <= body_index_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/keyed_frame_deframer_descrambler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_frame_deframer_descrambler
// Timing: the accepting edge loads the input register, and the result
//   register loads when that request advances. Throughput: 1 request per
//   cycle while out_stall does not hold the result register, set by the single
//   pass from input register through frame logic into the result register.
// Reset: synchronous active-low rst_n clears pipeline valids and frame state;
//   max_body_size returns to 8192.
// ----------------------------------------------------------------------------
module keyed_frame_deframer_descrambler (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input byte stream
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [kfdd_pkg::BYTE_W-1:0] in_rx_byte,
  // result stream
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [kfdd_pkg::BYTE_W-1:0] out_data_byte,
  output logic      [kfdd_pkg::BYTE_W-1:0] out_msg_key,
  output logic      [kfdd_pkg::LEN_W-1:0]  out_body_length,
  output logic      [kfdd_pkg::KIND_W-1:0] out_event_kind,
  output logic                             out_last_of_message,
  // configuration write
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [kfdd_pkg::LEN_W-1:0]  cfg_max_body_size
);
  import kfdd_pkg::*;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [LEN_W-1:0]  max_body_size_r;
  logic              out_valid_r;
  result_t           out_r;
  result_t           res;
  logic              out_hold;
  logic              adv;
  logic              in_fire;

  // The result register holds while it is full and the sink stalls.
  assign out_hold = out_valid_r && out_stall;
  // Advance the input register's request into the frame logic when the
  // result register can take whatever it produces.
  assign adv      = s1_valid_r && !out_hold;
  // Take a new request whenever the input register is empty or advancing.
  assign in_stall = s1_valid_r && out_hold;
  assign in_fire  = in_valid && !in_stall;

  // Register always writable; user writes only while block idle, not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_size_r <= MAX_BODY_RST;
    end else if (cfg_valid) begin
      max_body_size_r <= cfg_max_body_size;
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  kfdd_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .rx_byte       (s1_byte_r),
    .max_body_size (max_body_size_r),
    .res           (res)
  );

  // Result register: load on advance, drop when the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data_byte       = out_r.data_byte;
  assign out_msg_key         = out_r.msg_key;
  assign out_body_length     = out_r.body_length;
  assign out_event_kind      = out_r.event_kind;
  assign out_last_of_message = out_r.last_of_message;

endmodule
`default_nettype wire
